/* hdl/cursor_array_list_assert.svh */
// Assertion helpers used by the list top module. Each expects clk and rst_n in scope.
`ifndef CURSOR_ARRAY_LIST_ASSERT_SVH
`define CURSOR_ARRAY_LIST_ASSERT_SVH

// Same-cycle implication.
`define CAL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CAL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cal_pkg.sv */
package cal_pkg;

    localparam int WORD_W     = 32;
    localparam int POS_PORT_W = 10;
    localparam int CMD_W      = 4;
    localparam int STAT_W     = 2;
    // Read select runs in groups of 2**GRP_W cells.
    localparam int GRP_W      = 5;
    localparam int GRP_SIZE   = 2 ** GRP_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 4'd0,
        CMD_INSERT = 4'd1,
        CMD_APPEND = 4'd2,
        CMD_ERASE  = 4'd3,
        CMD_START  = 4'd4,
        CMD_END    = 4'd5,
        CMD_NEXT   = 4'd6,
        CMD_PREV   = 4'd7,
        CMD_MOVE   = 4'd8,
        CMD_READ   = 4'd9
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } stat_t;

    typedef struct packed {
        logic ins;
        logic app;
        logic ers;
    } cell_ctrl_t;

endpackage

/* hdl/cursor_array_list.sv */
// ch   handshake          dir  fields
// in   in_valid/ready     in   command, item_value, target_position
// out  out_valid/ready    out  status, result_value, insert_position, list_length, cursor_position
//
// A command is accepted when no earlier command is still in the select stage, so a new
// command is not taken until the last one has moved on; its result is held in the select
// stage and moves to the output register when the output is free. Every cell shifts in
// the accept cycle, so insert and erase cost the same as any other command; the word at
// the cursor is read by a two-step group select. Reset clears length, cursor and the
// valid flags; stored words are undefined until written. A stalled output holds the
// result in the select stage, and in_ready stays low.
`include "cursor_array_list_assert.svh"

module cursor_array_list #(
    parameter int CAPACITY = 512
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [cal_pkg::CMD_W-1:0]          command,
    input  logic signed [cal_pkg::WORD_W-1:0]  item_value,
    input  logic [cal_pkg::POS_PORT_W-1:0]     target_position,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [cal_pkg::STAT_W-1:0]         status,
    output logic signed [cal_pkg::WORD_W-1:0]  result_value,
    output logic [cal_pkg::POS_PORT_W-1:0]     insert_position,
    output logic [cal_pkg::POS_PORT_W-1:0]     list_length,
    output logic [cal_pkg::POS_PORT_W-1:0]     cursor_position
);

    localparam int POS_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (POS_W > cal_pkg::POS_PORT_W) ? POS_W : cal_pkg::POS_PORT_W;
    localparam int NGRP  = (CAPACITY + cal_pkg::GRP_SIZE - 1) / cal_pkg::GRP_SIZE;
    localparam int GI_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam logic [POS_W-1:0] CAP_P = POS_W'(CAPACITY);

    logic [POS_W-1:0] count_reg, count_next;
    logic [POS_W-1:0] cursor_reg, cursor_next;

    logic                 pend_reg;
    logic                 pend_next;
    cal_pkg::stat_t       pend_stat_reg, stat_c;
    logic [POS_W-1:0]     pend_placed_reg, placed_c;
    logic [POS_W-1:0]     pend_count_reg;
    logic [POS_W-1:0]     pend_cursor_reg;
    logic                 pend_need_reg, need_c;
    logic [GI_W-1:0]      pend_grp_reg;

    logic                                out_valid_reg, out_valid_next;
    cal_pkg::stat_t                      out_stat_reg;
    logic [cal_pkg::WORD_W-1:0]          out_value_reg;
    logic [cal_pkg::POS_PORT_W-1:0]      out_placed_reg;
    logic [cal_pkg::POS_PORT_W-1:0]      out_len_reg;
    logic [cal_pkg::POS_PORT_W-1:0]      out_cur_reg;

    cal_pkg::cmd_t           cmd;
    cal_pkg::cell_ctrl_t     ctrl_c;
    cal_pkg::cell_ctrl_t     ctrl_cells;
    logic                    accept;
    logic                    advance;
    logic [CMP_W-1:0]        count_x, cursor_x, target_x;
    logic [CMP_W-1:0]        placed_x, len_x, cur_out_x;
    logic [GI_W-1:0]         cur_grp;
    logic [cal_pkg::WORD_W-1:0] grp_word [NGRP];

    assign cmd       = cal_pkg::cmd_t'(command);
    assign in_ready  = !pend_reg;
    assign accept    = in_valid && in_ready;
    assign advance   = pend_reg && (!out_valid_reg || out_ready);
    assign count_x   = CMP_W'(count_reg);
    assign cursor_x  = CMP_W'(cursor_reg);
    assign target_x  = CMP_W'(target_position);
    assign cur_grp   = cursor_x[cal_pkg::GRP_W +: GI_W];

    always_comb
    begin
        stat_c      = cal_pkg::ST_OK;
        placed_c    = '0;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        need_c      = 1'b0;
        ctrl_c      = '0;
        case (cmd)
            cal_pkg::CMD_CLEAR:
            begin
                count_next  = '0;
                cursor_next = '0;
            end
            cal_pkg::CMD_INSERT:
            begin
                if (count_reg == CAP_P)
                begin
                    stat_c = cal_pkg::ST_FULL;
                end
                else
                begin
                    ctrl_c.ins = 1'b1;
                    placed_c   = cursor_reg;
                    count_next = count_reg + POS_W'(1);
                end
            end
            cal_pkg::CMD_APPEND:
            begin
                if (count_reg == CAP_P)
                begin
                    stat_c = cal_pkg::ST_FULL;
                end
                else
                begin
                    ctrl_c.app = 1'b1;
                    placed_c   = count_reg;
                    count_next = count_reg + POS_W'(1);
                end
            end
            cal_pkg::CMD_ERASE:
            begin
                if (cursor_reg >= count_reg)
                begin
                    stat_c = cal_pkg::ST_RANGE;
                end
                else
                begin
                    ctrl_c.ers = 1'b1;
                    need_c     = 1'b1;
                    count_next = count_reg - POS_W'(1);
                end
            end
            cal_pkg::CMD_START:
            begin
                cursor_next = '0;
            end
            cal_pkg::CMD_END:
            begin
                cursor_next = count_reg;
            end
            cal_pkg::CMD_NEXT:
            begin
                if (cursor_reg < count_reg)
                begin
                    cursor_next = cursor_reg + POS_W'(1);
                end
            end
            cal_pkg::CMD_PREV:
            begin
                if (cursor_reg != '0)
                begin
                    cursor_next = cursor_reg - POS_W'(1);
                end
            end
            cal_pkg::CMD_MOVE:
            begin
                if (target_x > count_x)
                begin
                    stat_c = cal_pkg::ST_RANGE;
                end
                else
                begin
                    cursor_next = POS_W'(target_position);
                end
            end
            cal_pkg::CMD_READ:
            begin
                if (cursor_reg >= count_reg)
                begin
                    stat_c = cal_pkg::ST_RANGE;
                end
                else
                begin
                    need_c = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign ctrl_cells = accept ? ctrl_c : '0;

    cal_chain #(
        .CAPACITY (CAPACITY),
        .POS_W    (POS_W),
        .NGRP     (NGRP)
    ) u_chain (
        .clk      (clk),
        .ctrl     (ctrl_cells),
        .cursor   (cursor_reg),
        .count    (count_reg),
        .item     (item_value),
        .capture  (accept),
        .cur_lo   (cursor_x[cal_pkg::GRP_W-1:0]),
        .grp_word (grp_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            cursor_reg <= '0;
        end
        else if (accept)
        begin
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (accept)
        begin
            pend_next = 1'b1;
        end
        else if (advance)
        begin
            pend_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_stat_reg   <= stat_c;
            pend_placed_reg <= placed_c;
            pend_count_reg  <= count_next;
            pend_cursor_reg <= cursor_next;
            pend_need_reg   <= need_c;
            pend_grp_reg    <= cur_grp;
        end
    end

    assign placed_x  = CMP_W'(pend_placed_reg);
    assign len_x     = CMP_W'(pend_count_reg);
    assign cur_out_x = CMP_W'(pend_cursor_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_stat_reg   <= pend_stat_reg;
            out_value_reg  <= pend_need_reg ? grp_word[pend_grp_reg] : '0;
            out_placed_reg <= placed_x[cal_pkg::POS_PORT_W-1:0];
            out_len_reg    <= len_x[cal_pkg::POS_PORT_W-1:0];
            out_cur_reg    <= cur_out_x[cal_pkg::POS_PORT_W-1:0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_stat_reg;
    assign result_value    = out_value_reg;
    assign insert_position = out_placed_reg;
    assign list_length     = out_len_reg;
    assign cursor_position = out_cur_reg;

    `CAL_ASSERT_IMP(a_cursor_in_list, 1'b1, cursor_reg <= count_reg, "cursor past end of list")
    `CAL_ASSERT_IMP(a_count_in_cap, 1'b1, count_reg <= CAP_P, "length above capacity")
    `CAL_ASSERT_NXT(a_accept_pends, accept, pend_reg, "accepted word not held in select stage")
    `CAL_ASSERT_NXT(a_pend_drains, pend_reg && !out_valid_reg, out_valid_reg && !pend_reg,
        "select stage did not move to output")

endmodule

/* hdl/cal_cell.sv */
module cal_cell #(
    parameter int POS_W = 10
) (
    input  logic                     clk,
    input  cal_pkg::cell_ctrl_t      ctrl,
    input  logic [POS_W-1:0]         cell_index,
    input  logic [POS_W-1:0]         cursor,
    input  logic [POS_W-1:0]         count,
    input  logic [cal_pkg::WORD_W-1:0] item,
    input  logic [cal_pkg::WORD_W-1:0] left_word,
    input  logic [cal_pkg::WORD_W-1:0] right_word,
    output logic [cal_pkg::WORD_W-1:0] word
);

    logic [cal_pkg::WORD_W-1:0] word_reg;
    logic [cal_pkg::WORD_W-1:0] word_next;
    logic                       take_item;
    logic                       take_left;
    logic                       take_right;

    assign take_item  = (ctrl.ins && (cell_index == cursor)) ||
                        (ctrl.app && (cell_index == count));
    assign take_left  = ctrl.ins && (cell_index > cursor);
    assign take_right = ctrl.ers && (cell_index >= cursor);

    always_comb
    begin
        word_next = word_reg;
        if (take_item)
        begin
            word_next = item;
        end
        else if (take_left)
        begin
            word_next = left_word;
        end
        else if (take_right)
        begin
            word_next = right_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

/* hdl/cal_chain.sv */
module cal_chain #(
    parameter int CAPACITY = 512,
    parameter int POS_W    = 10,
    parameter int NGRP     = 16
) (
    input  logic                         clk,
    input  cal_pkg::cell_ctrl_t          ctrl,
    input  logic [POS_W-1:0]             cursor,
    input  logic [POS_W-1:0]             count,
    input  logic [cal_pkg::WORD_W-1:0]   item,
    input  logic                         capture,
    input  logic [cal_pkg::GRP_W-1:0]    cur_lo,
    output logic [cal_pkg::WORD_W-1:0]   grp_word [NGRP]
);

    logic [cal_pkg::WORD_W-1:0] cell_word [CAPACITY];
    logic [cal_pkg::WORD_W-1:0] words_pad [NGRP][cal_pkg::GRP_SIZE];
    logic [cal_pkg::WORD_W-1:0] grp_reg   [NGRP];

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++)
        begin : g_cell
            logic [cal_pkg::WORD_W-1:0] left_w;
            logic [cal_pkg::WORD_W-1:0] right_w;

            if (k == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = cell_word[k-1];
            end

            // Last cell holds its word on erase; its content is past the end anyway.
            if (k == CAPACITY - 1)
            begin : g_last
                assign right_w = cell_word[k];
            end
            else
            begin : g_mid_r
                assign right_w = cell_word[k+1];
            end

            cal_cell #(
                .POS_W(POS_W)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .cell_index (POS_W'(k)),
                .cursor     (cursor),
                .count      (count),
                .item       (item),
                .left_word  (left_w),
                .right_word (right_w),
                .word       (cell_word[k])
            );
        end

        for (k = 0; k < NGRP * cal_pkg::GRP_SIZE; k++)
        begin : g_pad
            if (k < CAPACITY)
            begin : g_real
                assign words_pad[k / cal_pkg::GRP_SIZE][k % cal_pkg::GRP_SIZE] = cell_word[k];
            end
            else
            begin : g_zero
                assign words_pad[k / cal_pkg::GRP_SIZE][k % cal_pkg::GRP_SIZE] = '0;
            end
        end
    endgenerate

    // Capture the pre-update contents so an erase can shift on the same edge.
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int g = 0; g < NGRP; g++)
            begin
                grp_reg[g] <= words_pad[g][cur_lo];
            end
        end
    end

    assign grp_word = grp_reg;

endmodule

/* sim/cursor_array_list_tb.sv */
module cursor_array_list_tb;

    localparam int CAP          = 512;
    localparam int RAND_ITEMS   = 1350;
    localparam int STALL_LIMIT  = 1500;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 80;
    localparam int DIR_ROWS     = 26;

    // command codes with no operation behind them
    localparam logic [cal_pkg::CMD_W-1:0] CMD_UNUSED_LO = 4'd10;
    localparam logic [cal_pkg::CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [cal_pkg::STAT_W-1:0]     st;
        logic [cal_pkg::WORD_W-1:0]     rv;
        logic [cal_pkg::POS_PORT_W-1:0] ip;
        logic [cal_pkg::POS_PORT_W-1:0] len;
        logic [cal_pkg::POS_PORT_W-1:0] cur;
    } list_result_t;

    typedef struct packed {
        logic [cal_pkg::CMD_W-1:0]      cmd;
        logic [cal_pkg::WORD_W-1:0]     val;
        logic [cal_pkg::POS_PORT_W-1:0] tgt;
        logic                           typed;
        list_result_t                   res;
    } dir_row_t;

    typedef enum {MIX_MODE, FILL_MODE, DRAIN_MODE} phase_t;

    localparam list_result_t NO_RES = '0;

    // directed rows; results typed in where obvious, zero rows go through the predictor
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{cal_pkg::CMD_READ,   32'h0000_0000, 10'd0,    1'b1,
            '{cal_pkg::ST_RANGE, 32'h0, 10'd0, 10'd0, 10'd0}},
        '{cal_pkg::CMD_ERASE,  32'hFFFF_FFFF, 10'd0,    1'b1,
            '{cal_pkg::ST_RANGE, 32'h0, 10'd0, 10'd0, 10'd0}},
        '{cal_pkg::CMD_MOVE,   32'h0000_0000, 10'd1,    1'b1,
            '{cal_pkg::ST_RANGE, 32'h0, 10'd0, 10'd0, 10'd0}},
        '{cal_pkg::CMD_MOVE,   32'h0000_0000, 10'd1023, 1'b1,
            '{cal_pkg::ST_RANGE, 32'h0, 10'd0, 10'd0, 10'd0}},
        '{cal_pkg::CMD_PREV,   32'h0000_0000, 10'd0,    1'b1,
            '{cal_pkg::ST_OK,    32'h0, 10'd0, 10'd0, 10'd0}},
        '{cal_pkg::CMD_NEXT,   32'h0000_0000, 10'd0,    1'b1,
            '{cal_pkg::ST_OK,    32'h0, 10'd0, 10'd0, 10'd0}},
        '{cal_pkg::CMD_APPEND, 32'h7FFF_FFFF, 10'd0,    1'b1,
            '{cal_pkg::ST_OK,    32'h0, 10'd0, 10'd1, 10'd0}},
        '{cal_pkg::CMD_APPEND, 32'h8000_0000, 10'd0,    1'b1,
            '{cal_pkg::ST_OK,    32'h0, 10'd1, 10'd2, 10'd0}},
        '{cal_pkg::CMD_READ,   32'h0000_0000, 10'd0,    1'b1,
            '{cal_pkg::ST_OK, 32'h7FFF_FFFF, 10'd0, 10'd2, 10'd0}},
        '{cal_pkg::CMD_INSERT, 32'h0000_0000, 10'd0,    1'b1,
            '{cal_pkg::ST_OK,    32'h0, 10'd0, 10'd3, 10'd0}},
        '{cal_pkg::CMD_NEXT,   32'h0000_0000, 10'd0,    1'b1,
            '{cal_pkg::ST_OK,    32'h0, 10'd0, 10'd3, 10'd1}},
        '{cal_pkg::CMD_INSERT, 32'hFFFF_FFFF, 10'd0,    1'b1,
            '{cal_pkg::ST_OK,    32'h0, 10'd1, 10'd4, 10'd1}},
        '{cal_pkg::CMD_END,    32'h0000_0000, 10'd0,    1'b1,
            '{cal_pkg::ST_OK,    32'h0, 10'd0, 10'd4, 10'd4}},
        '{cal_pkg::CMD_READ,   32'h0000_0000, 10'd0,    1'b1,
            '{cal_pkg::ST_RANGE, 32'h0, 10'd0, 10'd4, 10'd4}},
        '{cal_pkg::CMD_ERASE,  32'h0000_0000, 10'd0,    1'b1,
            '{cal_pkg::ST_RANGE, 32'h0, 10'd0, 10'd4, 10'd4}},
        '{cal_pkg::CMD_MOVE,   32'h0000_0000, 10'd4,    1'b1,
            '{cal_pkg::ST_OK,    32'h0, 10'd0, 10'd4, 10'd4}},
        '{cal_pkg::CMD_MOVE,   32'h0000_0000, 10'd5,    1'b1,
            '{cal_pkg::ST_RANGE, 32'h0, 10'd0, 10'd4, 10'd4}},
        '{cal_pkg::CMD_PREV,   32'h0000_0000, 10'd0,    1'b1,
            '{cal_pkg::ST_OK,    32'h0, 10'd0, 10'd4, 10'd3}},
        '{cal_pkg::CMD_ERASE,  32'h0000_0000, 10'd0,    1'b1,
            '{cal_pkg::ST_OK, 32'h8000_0000, 10'd0, 10'd3, 10'd3}},
        '{cal_pkg::CMD_START,  32'h0000_0000, 10'd0,    1'b1,
            '{cal_pkg::ST_OK,    32'h0, 10'd0, 10'd3, 10'd0}},
        '{cal_pkg::CMD_MOVE,   32'h5A5A_A5A5, 10'd1,    1'b0, NO_RES},
        '{cal_pkg::CMD_ERASE,  32'h0000_0000, 10'd0,    1'b0, NO_RES},
        '{CMD_UNUSED_HI, 32'hFFFF_FFFF, 10'd1023, 1'b0, NO_RES},
        '{CMD_UNUSED_LO, 32'h0000_0000, 10'd0,  1'b0, NO_RES},
        '{cal_pkg::CMD_CLEAR,  32'h0000_0000, 10'd0,    1'b1,
            '{cal_pkg::ST_OK,    32'h0, 10'd0, 10'd0, 10'd0}},
        '{cal_pkg::CMD_READ,   32'h0000_0000, 10'd0,    1'b1,
            '{cal_pkg::ST_RANGE, 32'h0, 10'd0, 10'd0, 10'd0}}
    };

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  in_valid = 1'b0;
    logic                                  in_ready;
    logic [cal_pkg::CMD_W-1:0]             command = '0;
    logic signed [cal_pkg::WORD_W-1:0]     item_value = '0;
    logic [cal_pkg::POS_PORT_W-1:0]        target_position = '0;
    logic                                  out_valid;
    logic                                  out_ready = 1'b0;
    logic [cal_pkg::STAT_W-1:0]            status;
    logic signed [cal_pkg::WORD_W-1:0]     result_value;
    logic [cal_pkg::POS_PORT_W-1:0]        insert_position;
    logic [cal_pkg::POS_PORT_W-1:0]        list_length;
    logic [cal_pkg::POS_PORT_W-1:0]        cursor_position;

    // shadow copy of the list
    logic [cal_pkg::WORD_W-1:0] shadow_words [CAP];
    int unsigned                shadow_len = 0;
    int unsigned                shadow_cur = 0;

    list_result_t awaited_results [$];
    int           fail_count = 0;
    bit           quiet_tx = 1'b0;

    cursor_array_list #(.CAPACITY(CAP)) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .item_value      (item_value),
        .target_position (target_position),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .result_value    (result_value),
        .insert_position (insert_position),
        .list_length     (list_length),
        .cursor_position (cursor_position)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic list_result_t predict_list_result(
        logic [cal_pkg::CMD_W-1:0] cmd,
        logic [cal_pkg::WORD_W-1:0] val,
        logic [cal_pkg::POS_PORT_W-1:0] tgt);
        list_result_t r;
        r = '0;
        r.st = cal_pkg::ST_OK;
        case (cmd)
            cal_pkg::CMD_CLEAR:
            begin
                shadow_len = 0;
                shadow_cur = 0;
            end
            cal_pkg::CMD_INSERT:
                if (shadow_len >= CAP)
                    r.st = cal_pkg::ST_FULL;
                else
                begin
                    // shift the tail up one slot
                    for (int i = shadow_len; i > shadow_cur; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[shadow_cur] = val;
                    r.ip = 10'(shadow_cur);
                    shadow_len++;
                end
            cal_pkg::CMD_APPEND:
                if (shadow_len >= CAP)
                    r.st = cal_pkg::ST_FULL;
                else
                begin
                    shadow_words[shadow_len] = val;
                    r.ip = 10'(shadow_len);
                    shadow_len++;
                end
            cal_pkg::CMD_ERASE:
                if (shadow_cur >= shadow_len)
                    r.st = cal_pkg::ST_RANGE;
                else
                begin
                    r.rv = shadow_words[shadow_cur];
                    for (int i = shadow_cur; i + 1 < shadow_len; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_len--;
                end
            cal_pkg::CMD_START:
                shadow_cur = 0;
            cal_pkg::CMD_END:
                shadow_cur = shadow_len;
            cal_pkg::CMD_NEXT:
                if (shadow_cur < shadow_len)
                    shadow_cur++;
            cal_pkg::CMD_PREV:
                if (shadow_cur > 0)
                    shadow_cur--;
            cal_pkg::CMD_MOVE:
                if (tgt > shadow_len)
                    r.st = cal_pkg::ST_RANGE;
                else
                    shadow_cur = tgt;
            cal_pkg::CMD_READ:
                if (shadow_cur >= shadow_len)
                    r.st = cal_pkg::ST_RANGE;
                else
                    r.rv = shadow_words[shadow_cur];
            default:
                ;
        endcase
        r.len = 10'(shadow_len);
        r.cur = 10'(shadow_cur);
        return r;
    endfunction

    task automatic pick_command(input phase_t mode, output logic [cal_pkg::CMD_W-1:0] cmd,
                                output logic [cal_pkg::WORD_W-1:0] val,
                                output logic [cal_pkg::POS_PORT_W-1:0] tgt);
        int p;
        p = $urandom_range(0, 99);
        val = $urandom;
        // mostly in-range targets, now and then anything the port allows
        if ($urandom_range(0, 99) < 85)
            tgt = 10'($urandom_range(0, shadow_len));
        else
            tgt = 10'($urandom_range(0, 1023));
        case (mode)
            FILL_MODE:
                if (p < 45)      cmd = cal_pkg::CMD_INSERT;
                else if (p < 85) cmd = cal_pkg::CMD_APPEND;
                else if (p < 89) cmd = cal_pkg::CMD_READ;
                else if (p < 93) cmd = cal_pkg::CMD_MOVE;
                else if (p < 96) cmd = cal_pkg::CMD_NEXT;
                else             cmd = cal_pkg::CMD_PREV;
            DRAIN_MODE:
                if (p < 55)      cmd = cal_pkg::CMD_ERASE;
                else if (p < 65) cmd = cal_pkg::CMD_READ;
                else if (p < 72) cmd = cal_pkg::CMD_START;
                else if (p < 80) cmd = cal_pkg::CMD_MOVE;
                else if (p < 88) cmd = cal_pkg::CMD_NEXT;
                else if (p < 94) cmd = cal_pkg::CMD_PREV;
                else if (p < 97) cmd = cal_pkg::CMD_END;
                else             cmd = cal_pkg::CMD_INSERT;
            default:
                if (p < 20)      cmd = cal_pkg::CMD_INSERT;
                else if (p < 40) cmd = cal_pkg::CMD_APPEND;
                else if (p < 55) cmd = cal_pkg::CMD_ERASE;
                else if (p < 62) cmd = cal_pkg::CMD_READ;
                else if (p < 67) cmd = cal_pkg::CMD_START;
                else if (p < 72) cmd = cal_pkg::CMD_END;
                else if (p < 79) cmd = cal_pkg::CMD_NEXT;
                else if (p < 85) cmd = cal_pkg::CMD_PREV;
                else if (p < 93) cmd = cal_pkg::CMD_MOVE;
                else if (p < 95) cmd = cal_pkg::CMD_CLEAR;
                else             cmd = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        endcase
    endtask

    task automatic drive_word(input logic [cal_pkg::CMD_W-1:0] cmd,
                              input logic [cal_pkg::WORD_W-1:0] val,
                              input logic [cal_pkg::POS_PORT_W-1:0] tgt, input logic typed,
                              input list_result_t typed_res);
        int gap;
        list_result_t res;
        gap = quiet_tx ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        command         <= cmd;
        item_value      <= val;
        target_position <= tgt;
        do
            @(posedge clk);
        while (!in_ready);
        res = predict_list_result(cmd, val, tgt);
        awaited_results.push_back(typed ? typed_res : res);
    endtask

    // receiver: random stalls, quiet windows, one long hold-off
    initial
    begin : result_sink
        int stall;
        int taken;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken == HOLD_AT)
                stall = HOLD_CYCLES;
            else if ((taken >= 300 && taken < 420) || (taken >= 1100 && taken < 1180))
                stall = 0;
            else
                stall = $urandom_range(0, 7);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    always @(posedge clk)
    begin : result_check
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result word with nothing awaited");
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.st)
                begin
                    $error("status: expected %0d, actual %0d", want.st, status);
                    fail_count++;
                end
                if (result_value !== want.rv)
                begin
                    $error("result_value: expected %h, actual %h", want.rv, result_value);
                    fail_count++;
                end
                if (insert_position !== want.ip)
                begin
                    $error("insert_position: expected %0d, actual %0d", want.ip,
                           insert_position);
                    fail_count++;
                end
                if (list_length !== want.len)
                begin
                    $error("list_length: expected %0d, actual %0d", want.len, list_length);
                    fail_count++;
                end
                if (cursor_position !== want.cur)
                begin
                    $error("cursor_position: expected %0d, actual %0d", want.cur,
                           cursor_position);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("cursor_array_list test failed");
        $finish;
    end

    initial
    begin : stimulus
        phase_t                         mode;
        logic [cal_pkg::CMD_W-1:0]      c;
        logic [cal_pkg::WORD_W-1:0]     v;
        logic [cal_pkg::POS_PORT_W-1:0] t;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
            drive_word(dir_rows[r].cmd, dir_rows[r].val, dir_rows[r].tgt,
                       dir_rows[r].typed, dir_rows[r].res);

        // mix, fill past full, drain, then mix again
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n < 250)
                mode = MIX_MODE;
            else if (n < 900)
                mode = FILL_MODE;
            else if (n < 1200)
                mode = DRAIN_MODE;
            else
                mode = MIX_MODE;
            quiet_tx = (n >= 300 && n < 420) || (n >= 1100 && n < 1180);
            pick_command(mode, c, v, t);
            drive_word(c, v, t, 1'b0, NO_RES);
        end
        in_valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("cursor_array_list test passed");
        else
            $display("cursor_array_list test failed");
        $finish;
    end

endmodule
